FILE: rtl/core/iplpm_pkg.sv
// ----------------------------------------------------------------------------
// iplpm_pkg: shared types and constants
// Command and status codes, sequencer states and fixed field widths for the
// IPv4 longest-prefix-match trie.
// ----------------------------------------------------------------------------
`default_nettype none

package iplpm_pkg;

    // Fixed field widths of the request and result ports
    localparam int ADDR_W    = 32;
    localparam int LEN_W     = 6;
    localparam int IN_HOP_W  = 16;
    localparam int OUT_HOP_W = 16;

    // Deepest trie level (a full /32 prefix)
    localparam logic [LEN_W-1:0] MAX_LEN = 6'd32;

    // Request commands
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    // Result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

endpackage : iplpm_pkg

`default_nettype wire

FILE: rtl/core/iplpm_node_store.sv
// ----------------------------------------------------------------------------
// iplpm_node_store: trie node memory
// One write port and one read port with registered read data. Each entry
// holds both child links, the route valid flag and the next hop.
// ----------------------------------------------------------------------------
`default_nettype none

module iplpm_node_store
    import iplpm_pkg::*;
#(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 37
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule : iplpm_node_store

`default_nettype wire

FILE: rtl/core/ipv4_longest_prefix_match_trie.sv
// ----------------------------------------------------------------------------
// ipv4_longest_prefix_match_trie: binary-trie IPv4 route table
// Lookup returns the deepest route on the address path; insert allocates
// missing nodes and writes the next hop at the prefix node.
// ----------------------------------------------------------------------------
// Walk: a request walks one trie level per cycle through the node memory
//   read port; when the walk ends the sequencer passes through a result state
//   (ST_DONE) that raises the done strobe.
// Requests: one request at a time; busy stays high until the result cycle
//   ends, so a new request is taken only once the sequencer is back in idle.
// Reset: the root is cleared and the free pointer set to 1 at once; no
//   clearing pass, nodes are written as they are allocated.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_longest_prefix_match_trie
    import iplpm_pkg::*;
#(
    parameter int NODE_COUNT = 1024,
    parameter int HOP_BITS   = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 cmd,
    input  wire logic [ADDR_W-1:0]    address,
    input  wire logic [LEN_W-1:0]     prefix_length,
    input  wire logic [IN_HOP_W-1:0]  route_value,
    output logic                      done,
    output logic                      found,
    output logic [OUT_HOP_W-1:0]      hop_out,
    output logic                      status
);

    localparam int IDX_W  = $clog2(NODE_COUNT);
    localparam int FREE_W = $clog2(NODE_COUNT + 1);
    localparam int REC_W  = 2 * IDX_W + 1 + HOP_BITS;
    localparam logic [FREE_W-1:0] FREE_LIMIT = FREE_W'(NODE_COUNT);

    // Sequencer
    state_t state_reg, state_next;

    // Request registers
    logic                cmd_reg;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [LEN_W-1:0]    plen_reg;
    logic [HOP_BITS-1:0] hop_reg;

    // Walk registers
    logic [LEN_W-1:0]    depth_reg, depth_next;
    logic [IDX_W-1:0]    node_reg, node_next;
    logic                fresh_reg, fresh_next;
    logic                found_reg, found_next;
    logic [HOP_BITS-1:0] best_reg, best_next;
    logic                status_reg, status_next;
    logic [FREE_W-1:0]   free_reg, free_next;

    // Root node kept in flip-flops
    logic [IDX_W-1:0]    root_left_reg, root_right_reg;
    logic                root_valid_reg;
    logic [HOP_BITS-1:0] root_hop_reg;

    // Node store interface
    logic                mem_we;
    logic [REC_W-1:0]    mem_wdata;
    logic [IDX_W-1:0]    mem_raddr;
    logic [REC_W-1:0]    mem_rdata;

    // Current record and walk decisions
    logic [IDX_W-1:0]    rec_left, rec_right, child;
    logic                rec_valid;
    logic [HOP_BITS-1:0] rec_hop;
    logic [IDX_W-1:0]    wr_left, wr_right;
    logic                wr_valid;
    logic [HOP_BITS-1:0] wr_hop;
    logic                dir_bit, at_root, walking, is_insert;
    logic                lookup_end, ins_final, ins_full, ins_alloc;
    logic                walk_end, advance, wr_req, root_we;
    logic [LEN_W-1:0]    plen_sat;
    logic [31:0]         route_wide, best_wide;
    logic [IDX_W-1:0]    free_idx;

    iplpm_node_store #(
        .DEPTH  (NODE_COUNT),
        .ADDR_W (IDX_W),
        .DATA_W (REC_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (node_reg),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // Request field shaping
    assign plen_sat   = (prefix_length > MAX_LEN) ? MAX_LEN : prefix_length;
    assign route_wide = 32'(route_value);
    assign free_idx   = free_reg[IDX_W-1:0];

    // Record of the node at the current level: fresh nodes are known empty
    assign at_root = (depth_reg == '0);
    always_comb
    begin
        if (fresh_reg)
        begin
            rec_left  = '0;
            rec_right = '0;
            rec_valid = 1'b0;
            rec_hop   = '0;
        end
        else if (at_root)
        begin
            rec_left  = root_left_reg;
            rec_right = root_right_reg;
            rec_valid = root_valid_reg;
            rec_hop   = root_hop_reg;
        end
        else
        begin
            rec_left  = mem_rdata[IDX_W-1:0];
            rec_right = mem_rdata[2*IDX_W-1:IDX_W];
            rec_hop   = mem_rdata[2*IDX_W+HOP_BITS-1:2*IDX_W];
            rec_valid = mem_rdata[REC_W-1];
        end
    end

    // Walk decisions for the current level
    assign dir_bit    = addr_reg[ADDR_W-1];
    assign child      = dir_bit ? rec_right : rec_left;
    assign walking    = (state_reg == ST_WALK);
    assign is_insert  = (cmd_reg == CMD_INSERT);
    assign lookup_end = (depth_reg == MAX_LEN) || (child == '0);
    assign ins_final  = (depth_reg == plen_reg);
    assign ins_full   = !ins_final && (child == '0) && (free_reg == FREE_LIMIT);
    assign ins_alloc  = !ins_final && (child == '0) && (free_reg != FREE_LIMIT);
    assign walk_end   = is_insert ? (ins_final || ins_full) : lookup_end;
    assign advance    = walking && !walk_end;
    assign mem_raddr  = child;

    // Record written back: route at the prefix node, new link, or empty node
    always_comb
    begin
        wr_left  = rec_left;
        wr_right = rec_right;
        wr_valid = rec_valid;
        wr_hop   = rec_hop;
        if (ins_final)
        begin
            wr_valid = 1'b1;
            wr_hop   = hop_reg;
        end
        else if (ins_alloc)
        begin
            if (dir_bit)
            begin
                wr_right = free_idx;
            end
            else
            begin
                wr_left = free_idx;
            end
        end
        else
        begin
            wr_left  = '0;
            wr_right = '0;
            wr_valid = 1'b0;
            wr_hop   = '0;
        end
    end

    assign wr_req    = walking && is_insert && (ins_final || ins_alloc || (ins_full && fresh_reg));
    assign mem_we    = wr_req && !at_root;
    assign root_we   = wr_req && at_root;
    assign mem_wdata = {wr_valid, wr_hop, wr_right, wr_left};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (walk_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        busy = 1'b1;
        done = 1'b0;
        unique case (state_reg)
            ST_IDLE: busy = 1'b0;
            ST_WALK: busy = 1'b1;
            ST_DONE: done = 1'b1;
            default: busy = 1'b1;
        endcase
    end

    assign best_wide = 32'(best_reg);
    assign found     = found_reg;
    assign hop_out   = best_wide[OUT_HOP_W-1:0];
    assign status    = status_reg;

    // Datapath next values
    always_comb
    begin
        addr_next   = addr_reg;
        depth_next  = depth_reg;
        node_next   = node_reg;
        fresh_next  = fresh_reg;
        found_next  = found_reg;
        best_next   = best_reg;
        status_next = status_reg;
        free_next   = free_reg;
        if ((state_reg == ST_IDLE) && start)
        begin
            addr_next   = address;
            depth_next  = '0;
            node_next   = '0;
            fresh_next  = 1'b0;
            status_next = STATUS_OK;
            found_next  = (cmd == CMD_LOOKUP) ? root_valid_reg : 1'b0;
            best_next   = (cmd == CMD_LOOKUP) ? root_hop_reg : '0;
        end
        else if (walking)
        begin
            // deepest route seen so far on the lookup path
            if (!is_insert && !at_root && rec_valid)
            begin
                found_next = 1'b1;
                best_next  = rec_hop;
            end
            if (is_insert && ins_full)
            begin
                status_next = STATUS_FULL;
            end
            if (advance)
            begin
                addr_next  = {addr_reg[ADDR_W-2:0], 1'b0};
                depth_next = depth_reg + LEN_W'(1);
                if (is_insert && ins_alloc)
                begin
                    node_next  = free_idx;
                    fresh_next = 1'b1;
                    free_next  = free_reg + FREE_W'(1);
                end
                else
                begin
                    node_next  = child;
                    fresh_next = 1'b0;
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            free_reg       <= FREE_W'(1);
            root_left_reg  <= '0;
            root_right_reg <= '0;
            root_valid_reg <= 1'b0;
            root_hop_reg   <= '0;
            depth_reg      <= '0;
            fresh_reg      <= 1'b0;
            found_reg      <= 1'b0;
            status_reg     <= STATUS_OK;
        end
        else
        begin
            state_reg  <= state_next;
            free_reg   <= free_next;
            depth_reg  <= depth_next;
            fresh_reg  <= fresh_next;
            found_reg  <= found_next;
            status_reg <= status_next;
            if (root_we)
            begin
                root_left_reg  <= wr_left;
                root_right_reg <= wr_right;
                root_valid_reg <= wr_valid;
                root_hop_reg   <= wr_hop;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        node_reg <= node_next;
        best_reg <= best_next;
        if ((state_reg == ST_IDLE) && start)
        begin
            cmd_reg  <= cmd;
            plen_reg <= plen_sat;
            hop_reg  <= route_wide[HOP_BITS-1:0];
        end
    end

    // Checks
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted request did not start a walk");

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (free_reg != '0) && (free_reg <= FREE_LIMIT))
        else $error("free node pointer out of range");

    a_full_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STATUS_FULL)) |-> !found)
        else $error("store full reported together with a match");

    a_fresh_not_root: assert property (@(posedge clk) disable iff (!rst_n)
        (walking && fresh_reg) |-> !at_root)
        else $error("root marked as newly allocated");

endmodule : ipv4_longest_prefix_match_trie

`default_nettype wire
